/* src/rom_io_ram_bank_mapper_defines.svh */
// Assertion macros for the ROM/IO bank mapper checker.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ROM_IO_RAM_BANK_MAPPER_DEFINES_SVH
`define ROM_IO_RAM_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RIOBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("riobm assertion failed");

// Next-cycle implication, checked out of reset.
`define RIOBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("riobm assertion failed");

`endif

/* src/riobm_pkg.sv */
// Shared types and constants for the ROM/IO bank mapper.
// No dependencies.
`default_nettype none

package riobm_pkg;

  // Event codes
  localparam logic [2:0] OP_LOW_WR  = 3'd0;
  localparam logic [2:0] OP_WIN_RD  = 3'd1;
  localparam logic [2:0] OP_VID_WR  = 3'd2;
  localparam logic [2:0] OP_BANK    = 3'd3;
  localparam logic [2:0] OP_IRQ_ACK = 3'd4;

  // Target codes
  localparam logic [2:0] TGT_NONE  = 3'd0;
  localparam logic [2:0] TGT_RAM   = 3'd1;
  localparam logic [2:0] TGT_FDC   = 3'd2;
  localparam logic [2:0] TGT_IEEE  = 3'd3;
  localparam logic [2:0] TGT_VPIA  = 3'd4;
  localparam logic [2:0] TGT_LOCAL = 3'd5;

  // Window slots, offset bits 11:8
  localparam logic [3:0] SLOT_FDC  = 4'h1;
  localparam logic [3:0] SLOT_KBD  = 4'h2;
  localparam logic [3:0] SLOT_IEEE = 4'h9;
  localparam logic [3:0] SLOT_VPIA = 4'hC;

  // Bank modes
  localparam logic [1:0] MODE_ROM  = 2'd0;
  localparam logic [1:0] MODE_RAM  = 2'd1;
  localparam logic [1:0] MODE_ATTR = 2'd2;

  localparam logic [1:0]  WINDOW_HI   = 2'b10;   // address bits 13:12 of 0x2000
  localparam logic [16:0] WINDOW_BASE = 17'h02000;
  localparam logic [16:0] ATTR_BASE   = 17'h10000;
  localparam logic [16:0] CHAR_BASE   = 17'h0F000;
  localparam logic [7:0]  ATTR_MASK   = 8'h7F;
  localparam logic [7:0]  IRQ_VECTOR  = 8'hF8;
  localparam logic [7:0]  BUS_IDLE    = 8'hFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [13:0] address;
    logic [7:0]  data;
    logic [63:0] key_rows;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [16:0] target_address;
    logic        is_write;
    logic [7:0]  write_data;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic       rom_io_on;
    logic       attr_on;
    logic [1:0] saved_mode;
    logic       in_irq;
  } bank_state_t;

  // Keyboard row wired to each select bit (rows 2..5 are rotated on the board)
  function automatic logic [2:0] kbd_row(input logic [2:0] sel);
    logic [2:0] row;
    row = 3'd0;
    case (sel)
      3'd0: row = 3'd0;
      3'd1: row = 3'd1;
      3'd2: row = 3'd3;
      3'd3: row = 3'd4;
      3'd4: row = 3'd5;
      3'd5: row = 3'd2;
      3'd6: row = 3'd6;
      default: row = 3'd7;
    endcase
    return row;
  endfunction

endpackage

`default_nettype wire

/* src/riobm_decode.sv */
// Event decoder: routes one bus event and computes the next bank state.
// Depends on riobm_pkg.
`default_nettype none

module riobm_decode
  import riobm_pkg::*;
(
  input  wire in_item_t    item_i,
  input  wire bank_state_t state_i,
  output out_item_t        res_o,
  output bank_state_t      state_nxt_o
);

  logic [11:0] off;
  logic        ram_en;
  logic [2:0]  dev_tgt;
  logic [16:0] dev_reg;
  logic [7:0]  kbd_val;

  assign off    = item_i.address[11:0];
  assign ram_en = !state_i.rom_io_on || (state_i.in_irq && state_i.saved_mode == MODE_RAM);

  always_comb begin
    dev_tgt = TGT_NONE;
    dev_reg = '0;
    unique case (off[11:8])
      SLOT_FDC: begin
        dev_tgt = TGT_FDC;
        dev_reg = {5'd0, off};
      end
      SLOT_IEEE: begin
        dev_tgt = TGT_IEEE;
        dev_reg = {15'd0, off[1:0]};
      end
      SLOT_VPIA: begin
        dev_tgt = TGT_VPIA;
        dev_reg = {15'd0, off[1:0]};
      end
      default: begin
        dev_tgt = TGT_NONE;
        dev_reg = '0;
      end
    endcase
  end

  // Active-low rows: AND every row whose select bit is set
  always_comb begin
    kbd_val = BUS_IDLE;
    for (int b = 0; b < 8; b++) begin
      if (off[b]) begin
        kbd_val = kbd_val & item_i.key_rows[{kbd_row(3'(b)), 3'b000} +: 8];
      end
    end
  end

  always_comb begin
    res_o       = '0;
    state_nxt_o = state_i;
    unique case (item_i.opcode)
      OP_LOW_WR: begin
        if (ram_en) begin
          res_o.target         = TGT_RAM;
          res_o.target_address = {3'd0, item_i.address};
          res_o.is_write       = 1'b1;
          res_o.write_data     = item_i.data;
        end else if (item_i.address[13:12] == WINDOW_HI && dev_tgt != TGT_NONE) begin
          res_o.target         = dev_tgt;
          res_o.target_address = dev_reg;
          res_o.is_write       = 1'b1;
          res_o.write_data     = item_i.data;
        end
      end
      OP_WIN_RD: begin
        if (!state_i.rom_io_on) begin
          res_o.target         = TGT_RAM;
          res_o.target_address = WINDOW_BASE | {5'd0, off};
        end else if (off[11:8] == SLOT_KBD) begin
          res_o.target    = TGT_LOCAL;
          res_o.read_data = kbd_val;
        end else if (dev_tgt == TGT_NONE) begin
          res_o.read_data = BUS_IDLE;
        end else begin
          res_o.target         = dev_tgt;
          res_o.target_address = dev_reg;
        end
      end
      OP_VID_WR: begin
        res_o.target   = TGT_RAM;
        res_o.is_write = 1'b1;
        if (state_i.attr_on) begin
          res_o.target_address = ATTR_BASE | {5'd0, off};
          res_o.write_data     = item_i.data | ATTR_MASK;
        end else begin
          res_o.target_address = CHAR_BASE | {5'd0, off};
          res_o.write_data     = item_i.data;
        end
      end
      OP_BANK: begin
        state_nxt_o.rom_io_on  = (item_i.address[1:0] != MODE_RAM);
        state_nxt_o.attr_on    = (item_i.address[1:0] == MODE_ATTR);
        state_nxt_o.saved_mode = item_i.address[1:0];
        state_nxt_o.in_irq     = 1'b0;
      end
      OP_IRQ_ACK: begin
        state_nxt_o.rom_io_on = 1'b1;
        state_nxt_o.attr_on   = 1'b0;
        state_nxt_o.in_irq    = 1'b1;
        res_o.target          = TGT_LOCAL;
        res_o.read_data       = IRQ_VECTOR;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rom_io_ram_bank_mapper.sv */
// ROM/IO bank mapper, top level: input register, decode, result register.
// Events pass from the input register through decode to the result register.
// One event per cycle unless output stalls; bank state updates as events decode.
// Reset (rst_n low, synchronous): both stages empty, ROM/IO window on,
// attribute plane off, saved mode 0, not in interrupt. Depends on riobm_pkg.
`default_nettype none

module rom_io_ram_bank_mapper
  import riobm_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire           out_stall,
  output out_item_t     out_item
);

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  bank_state_t state_r, state_nxt;
  out_item_t   dec_res;

  logic s2_load, s1_adv, in_xfer;

  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_load;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_xfer  = in_valid && !in_stall;

  riobm_decode u_decode (
    .item_i      (s1_item_r),
    .state_i     (state_r),
    .res_o       (dec_res),
    .state_nxt_o (state_nxt)
  );

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !s2_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      state_r.rom_io_on  <= 1'b1;
      state_r.attr_on    <= 1'b0;
      state_r.saved_mode <= MODE_ROM;
      state_r.in_irq     <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= dec_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* src/riobm_checker.sv */
// Port-level checker for the ROM/IO bank mapper, bound to the top level.
// Depends on riobm_pkg and rom_io_ram_bank_mapper_defines.svh.
`default_nettype none
`include "rom_io_ram_bank_mapper_defines.svh"

module riobm_checker
  import riobm_pkg::*;
(
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_stall,
  input wire in_item_t  in_item,
  input wire            out_valid,
  input wire            out_stall,
  input wire out_item_t out_item
);

  // Input backs up only behind a full, stalled result register
  `RIOBM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // A stalled input transfer holds
  `RIOBM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))

  // A stalled result holds
  `RIOBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // No target means nothing addressed or written
  `RIOBM_ASSERT_NOW(a_none_clean, out_valid && out_item.target == TGT_NONE,
    out_item.target_address == '0 && !out_item.is_write && out_item.write_data == '0)

  // Local data is a read only
  `RIOBM_ASSERT_NOW(a_local_read, out_valid && out_item.target == TGT_LOCAL,
    !out_item.is_write && out_item.target_address == '0 && out_item.write_data == '0)

endmodule

bind rom_io_ram_bank_mapper riobm_checker u_riobm_checker (.*);

`default_nettype wire
